>>> hw/rtl/icrs_pkg.sv
// icrs_pkg: shared widths, constants and controller/datapath command types
// for the inverse cube root series block.
// No dependencies.
package icrs_pkg;

   // field widths
   localparam int ARG_W      = 31;   // argument, signed Q1.30
   localparam int TERM_W     = 32;   // series term, signed
   localparam int SUM_W      = 42;   // partial sum, signed Q12.30
   localparam int CNT_W      = 7;    // term_count register
   localparam int K_W        = 8;    // term index, holds count + 1
   localparam int DEN_W      = 9;    // 3k-3 and 3k-5 for k up to 127
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // term count limit
   localparam int MAX_TERMS  = 64;

   // divider: 32 quotient bits, 8 per cycle
   localparam int QUO_W      = 32;
   localparam int DIV_BITS   = 8;
   localparam int DIV_STEPS  = QUO_W / DIV_BITS;
   localparam int DCNT_W     = $clog2(DIV_STEPS);

   localparam logic [TERM_W-1:0] TERM_MAX = 32'h7FFF_FFFF;

   // controller to datapath
   typedef struct packed {
      logic load;       // take argument, seed first term
      logic mul;        // |term| * |x|
      logic rnd;        // round product to fraction bits
      logic scale;      // times (3k-5), plus half divisor
      logic div_init;   // overflow check, seed remainder
      logic div_step;   // eight quotient bits
      logic acc;        // sign term, saturating add, next k
      logic emit;       // load result register
   } icrs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;       // another term to compute
   } icrs_status_type;

endpackage

>>> hw/rtl/icrs_dp.sv
// icrs_dp: datapath of the inverse cube root series block: term_count
// register, term multiplier, restoring divider, saturating accumulator.
// Depends on icrs_pkg.
module icrs_dp #(
   parameter int FRAC_BITS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [icrs_pkg::CNT_W-1:0]    csr_wdata,
   input  logic [icrs_pkg::ARG_W-1:0]    argument,
   input  icrs_pkg::icrs_cmd_type        cmd,
   output icrs_pkg::icrs_status_type     status,
   output logic [icrs_pkg::SUM_W-1:0]    partial_sum,
   output logic                          saturated
);
   import icrs_pkg::*;

   localparam int MAG_W   = 2 * ARG_W;
   localparam int Q_W     = MAG_W - FRAC_BITS;
   localparam int PROD_W  = Q_W + DEN_W;
   localparam int DRAW_W  = PROD_W + 1;
   localparam int LO_W    = QUO_W - 1;
   localparam int DIV_W   = (DRAW_W > LO_W + DEN_W + 1) ? DRAW_W : LO_W + DEN_W + 1;
   localparam int HI_W    = DIV_W - LO_W;
   localparam logic [TERM_W-1:0] ONE_TERM =
      (FRAC_BITS >= TERM_W - 1) ? TERM_MAX : (TERM_W'(1) << FRAC_BITS);
   localparam logic [MAG_W-1:0] RND_HALF = MAG_W'(1) << (FRAC_BITS - 1);

   // registers
   logic [CNT_W-1:0]  term_count_ff, term_count_in;
   logic [CNT_W-1:0]  n_ff;
   logic [K_W-1:0]    k_ff;
   logic [ARG_W-1:0]  x_ff;
   logic [TERM_W-1:0] term_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              sat_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [Q_W-1:0]    q_ff;
   logic [DIV_W-1:0]  dvd_ff;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              clamp_ff;
   logic [SUM_W-1:0]  out_sum_ff;
   logic              out_sat_ff;

   // combinational values
   logic [CNT_W-1:0]  n_lim;
   logic [K_W+1:0]    k3;
   logic [DEN_W-1:0]  num, den, den_half;
   logic [ARG_W-1:0]  mt, mx;
   logic [MAG_W-1:0]  mag_in, rnd_sum;
   logic [PROD_W-1:0] prod;
   logic [DIV_W-1:0]  dvd_in;
   logic [HI_W-1:0]   hi;
   logic [DEN_W:0]    trial;
   logic [LO_W-1:0]   r_mag;
   logic [TERM_W-1:0] term_in;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_in;
   logic              sum_hit;

   // configuration register
   always_comb begin
      term_count_in = csr_wen ? csr_wdata : term_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= CNT_W'(1);
      end else begin
         term_count_ff <= term_count_in;
      end
   end

   // term count limit and per-term factors
   assign n_lim    = (term_count_ff > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : term_count_ff;
   assign k3       = {2'b00, k_ff} + {1'b0, k_ff, 1'b0};
   assign num      = DEN_W'(k3 - (K_W+2)'(5));
   assign den      = DEN_W'(k3 - (K_W+2)'(3));
   assign den_half = den >> 1;
   assign status.more = ({1'b0, n_ff} >= k_ff);

   // magnitude product
   assign mt     = term_ff[TERM_W-1] ? ARG_W'(~term_ff + TERM_W'(1)) : term_ff[ARG_W-1:0];
   assign mx     = x_ff[ARG_W-1] ? (~x_ff + ARG_W'(1)) : x_ff;
   assign mag_in = MAG_W'(mt) * MAG_W'(mx);

   // rounding and scaling
   assign rnd_sum = mag_ff + RND_HALF;
   assign prod    = PROD_W'(q_ff) * PROD_W'(num);
   assign dvd_in  = DIV_W'(prod) + DIV_W'(den_half);
   assign hi      = dvd_ff[DIV_W-1:LO_W];

   // eight restoring division steps
   always_comb begin
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial  = {rem_in, low_in[QUO_W-1]};
         low_in = low_in << 1;
         if (trial >= {1'b0, den}) begin
            rem_in = DEN_W'(trial - {1'b0, den});
            quo_in = {quo_in[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_in[QUO_W-2:0], 1'b0};
         end
      end
   end

   // signed next term and saturating sum
   assign r_mag    = clamp_ff ? TERM_MAX[LO_W-1:0] : quo_ff[LO_W-1:0];
   assign term_in  = (term_ff[TERM_W-1] != x_ff[ARG_W-1]) ? {1'b0, r_mag}
                                                         : (~{1'b0, r_mag} + TERM_W'(1));
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff}
                   + {{(SUM_W+1-TERM_W){term_in[TERM_W-1]}}, term_in};

   always_comb begin
      sum_hit = 1'b0;
      sum_in  = sum_wide[SUM_W-1:0];
      unique case (sum_wide[SUM_W:SUM_W-1])
         2'b01: begin
            sum_hit = 1'b1;
            sum_in  = {1'b0, {(SUM_W-1){1'b1}}};
         end
         2'b10: begin
            sum_hit = 1'b1;
            sum_in  = {1'b1, {(SUM_W-1){1'b0}}};
         end
         default: begin
            sum_hit = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= argument;
         n_ff   <= n_lim;
         k_ff   <= K_W'(2);
         sat_ff <= 1'b0;
         if (n_lim == '0) begin
            term_ff <= '0;
            sum_ff  <= '0;
         end else begin
            term_ff <= ONE_TERM;
            sum_ff  <= SUM_W'(ONE_TERM);
         end
      end
      if (cmd.mul) begin
         mag_ff <= mag_in;
      end
      if (cmd.rnd) begin
         q_ff <= rnd_sum[MAG_W-1:FRAC_BITS];
      end
      if (cmd.scale) begin
         dvd_ff <= dvd_in;
      end
      // remainder starts with the bits above the low 32, which then shift in
      if (cmd.div_init) begin
         clamp_ff <= (hi >= HI_W'(den));
         rem_ff   <= hi[DEN_W:1];
         low_ff   <= dvd_ff[QUO_W-1:0];
         quo_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
      end
      if (cmd.acc) begin
         term_ff <= term_in;
         sum_ff  <= sum_in;
         sat_ff  <= sat_ff | sum_hit;
         k_ff    <= k_ff + K_W'(1);
      end
      if (cmd.emit) begin
         out_sum_ff <= sum_ff;
         out_sat_ff <= sat_ff;
      end
   end

   assign partial_sum = out_sum_ff;
   assign saturated   = out_sat_ff;

endmodule

>>> hw/rtl/icrs_ctrl.sv
// icrs_ctrl: sequencer of the inverse cube root series block; walks each
// term through multiply, round, scale, divide and accumulate.
// Depends on icrs_pkg.
module icrs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  icrs_pkg::icrs_status_type  status,
   output icrs_pkg::icrs_cmd_type     cmd
);
   import icrs_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOOP  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_RND   = 4'd3;
   localparam logic [3:0] S_SCALE = 4'd4;
   localparam logic [3:0] S_DINIT = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_ACC   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      dcnt_in  = dcnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            state_in = status.more ? S_MUL : S_DONE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_RND;
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            dcnt_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_LOOP;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/inverse_cube_root_series.sv
// inverse_cube_root_series: top level joining the sequencer and datapath.
// Depends on icrs_pkg, icrs_ctrl, icrs_dp.
//
// Usage: each req beat carries a signed Q1.30 argument x; each rsp beat
// returns the partial sum of the first N terms of the binomial series for
// (1+x)^(-1/3) as signed Q12.30, with a saturation flag in tuser.
// N is term_count, written through csr_wen/csr_wdata while the block is
// idle; values above 64 act as 64, and zero returns a sum of zero.
// Sequence: each term after the first passes through a 31x31 multiply,
// rounding, a scale multiply, an overflow check, an 8-bit-per-cycle
// restoring divider and accumulation. After the last term the result is
// loaded into the output register, and req_tready returns as it is loaded.
// One item is in work at a time; a finished result sits in the output
// register, and req_tready returns while it waits. If rsp_tready stays low
// the next item runs to completion and then holds until the register frees.
// Reset (synchronous) returns to idle, drops rsp_tvalid and sets
// term_count to 1.
module inverse_cube_root_series #(
   parameter int FRAC_BITS = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [icrs_pkg::CNT_W-1:0]        csr_wdata,   // term_count
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [icrs_pkg::REQ_DATA_W-1:0]   req_tdata,   // [30:0] argument
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [icrs_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [41:0] partial_sum
   output logic                              rsp_tuser    // [0] saturated
);
   import icrs_pkg::*;

   icrs_cmd_type    cmd;
   icrs_status_type status;
   logic [SUM_W-1:0] partial_sum;
   logic             saturated;

   icrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   icrs_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .argument    (req_tdata[ARG_W-1:0]),
      .cmd         (cmd),
      .status      (status),
      .partial_sum (partial_sum),
      .saturated   (saturated)
   );

   assign rsp_tdata = {{(RSP_DATA_W-SUM_W){1'b0}}, partial_sum};
   assign rsp_tuser = saturated;

endmodule

>>> hw/rtl/icrs_checker.sv
// icrs_checker: port-level assertions for inverse_cube_root_series, and
// the bind that attaches them. Depends on icrs_pkg.
module icrs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [icrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);
   import icrs_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // no result out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // one item at a time: ready drops after a req beat
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after a req beat");

   // a result cannot appear the cycle after its req beat
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too early");

   // padding above partial_sum stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:SUM_W] == '0)
      else $error("rsp_tdata padding not zero");

endmodule

bind inverse_cube_root_series icrs_checker u_icrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/sv/tb.sv
// tb: self-checking testbench for inverse_cube_root_series (binomial series
// for (1+x)^(-1/3)), directed table then random phases over term_count.
// Depends on icrs_pkg and the inverse_cube_root_series RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import icrs_pkg::*;

   localparam int      FRAC     = 30;
   localparam int      RAND_ITEMS = 1900;
   localparam longint  CYCLE_LIMIT = 4_000_000;
   localparam longint  SUM_HI   = 64'sd2199023255551;
   localparam longint  SUM_LO   = -64'sd2199023255552;
   localparam longint  TERM_HI  = 64'sd2147483647;
   localparam logic [SUM_W-1:0] ONE_SUM = 42'h0_4000_0000;

   typedef struct packed {
      logic [SUM_W-1:0] partial_sum;
      logic             saturated;
   } series_result_type;

   typedef struct {
      logic [CNT_W-1:0] count;
      logic [ARG_W-1:0] arg;
      bit               known;
      logic [SUM_W-1:0] sum;
   } stim_row_type;

   // DUT ports
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_wen    = 1'b0;
   logic [CNT_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // [30:0] argument
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [41:0] partial_sum
   logic                  rsp_tuser;          // [0] saturated

   // expectation typed in by the directed table, travels with the beat
   bit                    row_known  = 1'b0;
   logic [SUM_W-1:0]      row_sum    = '0;

   series_result_type     expected_sums[$];
   series_result_type     oldest;
   logic [CNT_W-1:0]      cur_term_count = 7'd1;
   int                    idle_pct = 22;
   int                    error_count = 0;
   longint                cycles = 0;
   int                    sent;
   int                    phase;
   int                    phase_items;
   logic [CNT_W-1:0]      pick;

   stim_row_type dir_rows [21] = '{
      '{7'd1,   31'h3FFF_FFFF, 1'b1, ONE_SUM},   // reset count, largest x
      '{7'd1,   31'h4000_0001, 1'b1, ONE_SUM},   // reset count, most negative x above -1
      '{7'd1,   31'h0000_0000, 1'b1, ONE_SUM},
      '{7'd0,   31'h0000_0000, 1'b1, '0},        // zero term count
      '{7'd0,   31'h4000_0000, 1'b1, '0},
      '{7'd2,   31'h0000_0000, 1'b1, ONE_SUM},   // x = 0 leaves only the first term
      '{7'd2,   31'h2000_0000, 1'b0, '0},
      '{7'd2,   31'h3FFF_FFFF, 1'b0, '0},
      '{7'd2,   31'h4000_0001, 1'b0, '0},
      '{7'd2,   31'h4000_0000, 1'b0, '0},        // magnitude one
      '{7'd3,   31'h3FFF_FFFF, 1'b0, '0},
      '{7'd5,   31'h4000_0000, 1'b0, '0},
      '{7'd64,  31'h0000_0000, 1'b1, ONE_SUM},
      '{7'd64,  31'h3FFF_FFFF, 1'b0, '0},
      '{7'd64,  31'h4000_0001, 1'b0, '0},
      '{7'd64,  31'h4000_0000, 1'b0, '0},        // x = -1 at the term limit
      '{7'd64,  31'h0000_0001, 1'b0, '0},
      '{7'd64,  31'h7FFF_FFFF, 1'b0, '0},
      '{7'd127, 31'h2AAA_AAAA, 1'b0, '0},        // above the term limit
      '{7'd127, 31'h5555_5555, 1'b0, '0},
      '{7'd100, 31'h1555_5555, 1'b0, '0}
   };

   inverse_cube_root_series #(.FRAC_BITS(FRAC)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // clamp into the Q12.30 range, note any clamp
   function automatic longint clamp_sum(longint s, inout bit hit);
      if (s > SUM_HI) begin
         hit = 1'b1;
         return SUM_HI;
      end
      if (s < SUM_LO) begin
         hit = 1'b1;
         return SUM_LO;
      end
      return s;
   endfunction

   // partial sum of the first count terms of (1+x)^(-1/3)
   function automatic series_result_type series_partial_sum(logic [ARG_W-1:0] arg,
                                                            logic [CNT_W-1:0] count);
      longint            x;
      longint            term;
      longint            acc;
      longint unsigned   mt, mx, q, r, num, den, one;
      int                n;
      bit                hit;
      bit                neg_t, neg_x;
      series_result_type res;
      x    = {{(64-ARG_W){arg[ARG_W-1]}}, arg};
      n    = (count > MAX_TERMS) ? MAX_TERMS : int'(count);
      acc  = 0;
      hit  = 1'b0;
      if (n >= 1) begin
         one = 64'd1 << FRAC;
         if (one > TERM_HI)
            one = TERM_HI;
         term = longint'(one);
         acc  = clamp_sum(term, hit);
         for (int k = 2; k <= n; k++) begin
            neg_t = term < 0;
            neg_x = x < 0;
            mt    = neg_t ? -term : term;
            mx    = neg_x ? -x : x;
            q     = (mt * mx + (64'd1 << (FRAC - 1))) >> FRAC;
            num   = 3 * k - 5;
            den   = 3 * k - 3;
            r     = (q * num + den / 2) / den;
            if (r > TERM_HI)
               r = TERM_HI;
            // sign is minus the product of the signs
            term  = (neg_t != neg_x) ? longint'(r) : -longint'(r);
            acc   = clamp_sum(acc + term, hit);
         end
      end
      res.partial_sum = acc[SUM_W-1:0];
      res.saturated   = hit;
      return res;
   endfunction

   function automatic logic [ARG_W-1:0] random_argument();
      logic [ARG_W-1:0] a;
      case ($urandom_range(9))
         0: begin
            a = ARG_W'($urandom_range(0, 255));
            if ($urandom_range(1))
               a = -a;
         end
         1: a = ARG_W'(31'h3FFF_FFFF - $urandom_range(0, 1023));   // near +1
         2: a = ARG_W'(31'h4000_0000 + $urandom_range(0, 1023));   // near -1, incl. -1
         default: a = ARG_W'($urandom());
      endcase
      return a;
   endfunction

   // sink: random backpressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= idle_pct);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // scoreboard: retire results first, then record new beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sums.size() == 0) begin
               $error("rsp beat with nothing expected: partial_sum %0h saturated %0b",
                      rsp_tdata[SUM_W-1:0], rsp_tuser);
               error_count++;
            end else begin
               oldest = expected_sums.pop_front();
               if (rsp_tdata[SUM_W-1:0] !== oldest.partial_sum) begin
                  $error("partial_sum: expected %0h, actual %0h",
                         oldest.partial_sum, rsp_tdata[SUM_W-1:0]);
                  error_count++;
               end
               if (rsp_tuser !== oldest.saturated) begin
                  $error("saturated: expected %0b, actual %0b",
                         oldest.saturated, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (row_known)
               expected_sums.push_back('{row_sum, 1'b0});
            else
               expected_sums.push_back(series_partial_sum(req_tdata[ARG_W-1:0],
                                                          cur_term_count));
         end
      end
   end

   // hold off until every result is back and the block is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_sums.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_term_count(input logic [CNT_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      cur_term_count = value;
   endtask

   // one req beat, with an optional random gap ahead of it
   task automatic send_argument(input logic [ARG_W-1:0] arg, input bit known,
                                input logic [SUM_W-1:0] sum);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, arg};
      row_known  <= known;
      row_sum    <= sum;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table; count changes only while idle
      foreach (dir_rows[i]) begin
         if (dir_rows[i].count != cur_term_count) begin
            drain();
            write_term_count(dir_rows[i].count);
         end
         send_argument(dir_rows[i].arg, dir_rows[i].known, dir_rows[i].sum);
      end

      // random phases, each at its own term count
      sent  = 0;
      phase = 0;
      while (sent < RAND_ITEMS) begin
         drain();
         case (phase)
            0: pick = 7'd64;
            1: pick = 7'd0;
            2: pick = 7'd127;
            3: pick = 7'd5;
            default:
               case ($urandom_range(9))
                  0: pick = 7'd0;
                  1: pick = 7'd1;
                  2: pick = CNT_W'($urandom_range(32, 127));
                  default: pick = CNT_W'($urandom_range(2, 12));
               endcase
         endcase
         write_term_count(pick);
         // one long stretch without any idling on either side
         idle_pct    = (phase == 3) ? 0 : 22;
         phase_items = (pick > 16) ? 30 : 120;
         for (int i = 0; i < phase_items; i++) begin
            send_argument(random_argument(), 1'b0, '0);
            sent++;
            if ($urandom_range(199) == 0)
               drain();
         end
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/icrs_pkg.sv
hw/rtl/icrs_dp.sv
hw/rtl/icrs_ctrl.sv
hw/rtl/inverse_cube_root_series.sv
hw/rtl/icrs_checker.sv
tb/sv/tb.sv
